### rtl/psh_pkg.sv
// Package: shared constants, types and command codes for the pair statistics histogram.
`timescale 1ns / 1ps
package psh_pkg;
    localparam int VW      = 32;
    localparam int BINS    = 16;
    localparam int BIDX_W  = $clog2(BINS);
    localparam int CW      = 32;
    localparam int DEPTH   = BINS * BINS;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam logic [VW-1:0] VMAX = {VW{1'b1}};

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_CLEAR  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_LOWER_A = 2'd0;
    localparam logic [1:0] REG_STEP_A  = 2'd1;
    localparam logic [1:0] REG_LOWER_B = 2'd2;
    localparam logic [1:0] REG_STEP_B  = 2'd3;

    // Start/done bundle between the top level and a lane.
    typedef struct packed {
        logic          start;
        logic [VW-1:0] value;
        logic [VW-1:0] count;
        logic [VW-1:0] lower;
        logic [VW-1:0] step;
    } lane_req_t;

    typedef struct packed {
        logic              done;
        logic [BIDX_W-1:0] bin;
    } lane_rsp_t;

    function automatic logic [VW-1:0] sat_add(input logic [VW-1:0] x, input logic [VW-1:0] y);
        logic [VW:0] s;
        s = {1'b0, x} + {1'b0, y};
        return s[VW] ? VMAX : s[VW-1:0];
    endfunction
endpackage

### rtl/psh_div.sv
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
module psh_div
    import psh_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [VW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [VW-1:0] quot,
    output logic [VW-1:0] rem
);
    localparam int CNT_W = $clog2(VW + 1);
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic [VW-1:0]    q_reg, r_reg, d_reg;
    logic [VW:0]      trial;
    logic [VW:0]      shifted;

    assign shifted = {r_reg, q_reg[VW-1]};
    assign trial   = shifted - {1'b0, d_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(VW);
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
            end else if (busy_reg) begin
                if (!trial[VW]) begin
                    r_reg <= trial[VW-1:0];
                    q_reg <= {q_reg[VW-2:0], 1'b1};
                end else begin
                    r_reg <= shifted[VW-1:0];
                    q_reg <= {q_reg[VW-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end
    assign quot = q_reg;
    assign rem  = r_reg;
endmodule

### rtl/psh_lane.sv
// One coordinate lane: running mean with error carry, min/max and bin index.
`timescale 1ns / 1ps
module psh_lane
    import psh_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  lane_req_t     req,
    output lane_rsp_t     rsp,
    output logic [VW-1:0] mean,
    output logic [VW-1:0] err,
    output logic [VW-1:0] big,
    output logic [VW-1:0] small_v
);
    typedef enum logic [2:0] {
        S_IDLE, S_DIV1, S_CORR, S_DIV2, S_BIN, S_DIVB, S_DONE
    } state_t;

    state_t        state_reg;
    logic [VW-1:0] mean_reg, err_reg, big_reg, small_reg, et_reg, v_reg, n_reg;
    logic [VW-1:0] lower_reg, step_reg;
    logic          neg_reg, gt_reg;
    logic [BIDX_W-1:0] bin_reg;
    logic          done_reg;

    logic          dstart;
    logic [VW-1:0] ddend, ddsor, dq, dr;
    logic          ddone;

    psh_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(dstart), .dividend(ddend),
        .divisor(ddsor), .done(ddone), .quot(dq), .rem(dr)
    );

    always_comb begin
        dstart = 1'b0;
        ddend  = '0;
        ddsor  = n_reg;
        unique case (state_reg)
            S_IDLE: begin
                dstart = req.start && (req.value != mean_reg);
                ddend  = (req.value > mean_reg) ? req.value - mean_reg
                                                : mean_reg - req.value;
                ddsor  = req.count;
            end
            S_CORR: begin
                dstart = 1'b1;
                ddend  = et_reg;
                ddsor  = n_reg - 1'b1;
            end
            S_BIN: begin
                dstart = (v_reg >= lower_reg);
                ddend  = v_reg - lower_reg;
                ddsor  = (step_reg == '0) ? VW'(1) : step_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            mean_reg  <= '0;
            err_reg   <= '0;
            big_reg   <= '0;
            small_reg <= VMAX;
            neg_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (req.start) begin
                    v_reg     <= req.value;
                    n_reg     <= req.count;
                    lower_reg <= req.lower;
                    step_reg  <= req.step;
                    gt_reg    <= req.value > mean_reg;
                    et_reg    <= err_reg;
                    if (req.value > big_reg)   big_reg   <= req.value;
                    if (req.value < small_reg) small_reg <= req.value;
                    state_reg <= (req.value != mean_reg) ? S_DIV1 : S_BIN;
                end
                S_DIV1: if (ddone) begin
                    err_reg <= dr;
                    // Fold the new remainder into the signed carried error.
                    if (gt_reg) begin
                        mean_reg <= mean_reg + dq;
                        if (neg_reg) begin
                            if (et_reg <= dr) begin
                                et_reg <= dr - et_reg; neg_reg <= 1'b0;
                            end else begin
                                et_reg <= et_reg - dr; neg_reg <= 1'b1;
                            end
                        end else begin
                            et_reg <= sat_add(et_reg, dr);
                        end
                    end else begin
                        mean_reg <= mean_reg - dq;
                        if (neg_reg) begin
                            et_reg <= sat_add(et_reg, dr);
                        end else if (et_reg <= dr) begin
                            et_reg <= dr - et_reg; neg_reg <= 1'b1;
                        end else begin
                            et_reg <= et_reg - dr; neg_reg <= 1'b0;
                        end
                    end
                    state_reg <= (n_reg >= VW'(2)) ? S_CORR : S_BIN;
                end
                S_CORR: state_reg <= S_DIV2;
                S_DIV2: if (ddone) begin
                    err_reg <= dr;
                    if (neg_reg) mean_reg <= (mean_reg >= dq) ? mean_reg - dq : '0;
                    else         mean_reg <= sat_add(mean_reg, dq);
                    state_reg <= S_BIN;
                end
                S_BIN: begin
                    if (v_reg < lower_reg) begin
                        bin_reg   <= '0;
                        state_reg <= S_DONE;
                        done_reg  <= 1'b1;
                    end else begin
                        state_reg <= S_DIVB;
                    end
                end
                S_DIVB: if (ddone) begin
                    bin_reg <= (dq >= VW'(BINS - 2)) ? BIDX_W'(BINS - 1)
                                                     : BIDX_W'(dq + 1'b1);
                    state_reg <= S_DONE;
                    done_reg  <= 1'b1;
                end
                S_DONE: state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.bin  = bin_reg;
    assign mean     = mean_reg;
    assign err      = err_reg;
    assign big      = big_reg;
    assign small_v  = small_reg;
endmodule

### rtl/psh_ram.sv
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module psh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule

### rtl/pair_stats_histogram_unit.sv
// Top level: pair statistics with a two-lane mean/bin core and a 2D histogram RAM.
// Insert: up to three divisions per lane, lanes in parallel, then a read-modify-write
// of the histogram entry; a read goes through the registered RAM output.
// One transaction at a time; the next is taken in the cycle after the result
// goes out, and a clear holds the input for its sweep.
// Reset: synchronous, active low; after reset a clearing pass sweeps every entry of
// the histogram RAM while s_tready stays low. Config writes are taken throughout.
`timescale 1ns / 1ps
module pair_stats_histogram_unit
    import psh_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // tdata: cmd[1:0], value_a[33:2], value_b[65:34], bin_row[69:66], bin_col[73:70], pad
    input  logic [79:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tdata: accepted[0], mean_a, mean_b, max_a, max_b, min_a, min_b,
    //        sample_count, bin_value (32 bits each from bit 1), pad
    output logic [263:0] m_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    typedef enum logic [2:0] {
        T_CLEAR, T_IDLE, T_LANES, T_RMW, T_READ, T_WAITR, T_OUT
    } state_t;

    state_t state_reg;
    logic [VW-1:0] lower_a_reg, step_a_reg, lower_b_reg, step_b_reg, count_reg;
    logic [ADDR_W-1:0] sweep_reg, addr_reg;
    logic [1:0] rw_reg;
    logic       acc_reg, lane_done_a_reg, lane_done_b_reg;
    logic [BIDX_W-1:0] bin_a_reg, bin_b_reg;
    logic [CW-1:0] binv_reg;

    cmd_t          cmd;
    logic [VW-1:0] va, vb;
    logic [3:0]    row, col;
    assign cmd = cmd_t'(s_tdata[1:0]);
    assign va  = s_tdata[33:2];
    assign vb  = s_tdata[65:34];
    assign row = s_tdata[69:66];
    assign col = s_tdata[73:70];

    // Configuration port.
    assign pready = 1'b1;
    always_comb begin
        unique case (paddr[3:2])
            REG_LOWER_A: prdata = lower_a_reg;
            REG_STEP_A:  prdata = step_a_reg;
            REG_LOWER_B: prdata = lower_b_reg;
            default:     prdata = step_b_reg;
        endcase
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lower_a_reg <= '0; step_a_reg <= VW'(1);
            lower_b_reg <= '0; step_b_reg <= VW'(1);
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_LOWER_A: lower_a_reg <= pwdata;
                REG_STEP_A:  step_a_reg  <= pwdata;
                REG_LOWER_B: lower_b_reg <= pwdata;
                default:     step_b_reg  <= pwdata;
            endcase
        end
    end

    // Lanes: one per coordinate.
    lane_req_t req_a, req_b;
    lane_rsp_t rsp_a, rsp_b;
    logic [VW-1:0] mean_a, err_a, big_a, small_a, mean_b, err_b, big_b, small_b;
    logic s_fire, ins_ok;

    assign s_tready = (state_reg == T_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign ins_ok   = (va <= VMAX - err_a) && (vb <= VMAX - err_b) && (count_reg != VMAX);

    assign req_a = '{start: s_fire && cmd == CMD_INSERT && ins_ok, value: va,
                     count: count_reg + 1'b1, lower: lower_a_reg, step: step_a_reg};
    assign req_b = '{start: s_fire && cmd == CMD_INSERT && ins_ok, value: vb,
                     count: count_reg + 1'b1, lower: lower_b_reg, step: step_b_reg};

    psh_lane u_lane_a (.aclk(aclk), .aresetn(aresetn), .req(req_a), .rsp(rsp_a),
        .mean(mean_a), .err(err_a), .big(big_a), .small_v(small_a));
    psh_lane u_lane_b (.aclk(aclk), .aresetn(aresetn), .req(req_b), .rsp(rsp_b),
        .mean(mean_b), .err(err_b), .big(big_b), .small_v(small_b));

    // Histogram memory.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr, ram_raddr;
    logic [CW-1:0]     ram_wdata, ram_rdata;

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = addr_reg;
        ram_wdata = ram_rdata + 1'b1;
        ram_raddr = addr_reg;
        if (state_reg == T_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = sweep_reg;
            ram_wdata = '0;
        end else if (state_reg == T_RMW && rw_reg == 2'd2) begin
            ram_we = 1'b1;
        end
    end

    psh_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_ram (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_CLEAR;
            sweep_reg <= '0;
            count_reg <= '0;
            m_tvalid  <= 1'b0;
            rw_reg    <= '0;
            lane_done_a_reg <= 1'b0;
            lane_done_b_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                T_CLEAR: begin
                    // Sweep the histogram one entry per cycle; hold a pending result.
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == ADDR_W'(DEPTH - 1))
                        state_reg <= (m_tvalid && !m_tready) ? T_OUT : T_IDLE;
                end
                T_IDLE: if (s_fire) begin
                    acc_reg  <= 1'b0;
                    binv_reg <= '0;
                    priority case (1'b1)
                        cmd == CMD_INSERT && ins_ok: begin
                            acc_reg   <= 1'b1;
                            count_reg <= count_reg + 1'b1;
                            lane_done_a_reg <= 1'b0;
                            lane_done_b_reg <= 1'b0;
                            state_reg <= T_LANES;
                        end
                        cmd == CMD_CLEAR: begin
                            sweep_reg <= '0;
                            state_reg <= T_CLEAR;
                            m_tvalid  <= 1'b1;
                        end
                        cmd == CMD_READ: begin
                            addr_reg  <= {row[BIDX_W-1:0], col[BIDX_W-1:0]};
                            state_reg <= T_READ;
                        end
                        default: begin
                            state_reg <= T_OUT;
                            m_tvalid  <= 1'b1;
                        end
                    endcase
                end
                T_LANES: begin
                    if (rsp_a.done) begin lane_done_a_reg <= 1'b1; bin_a_reg <= rsp_a.bin; end
                    if (rsp_b.done) begin lane_done_b_reg <= 1'b1; bin_b_reg <= rsp_b.bin; end
                    // Merge: both lanes finished, combine their bins into an address.
                    if (lane_done_a_reg && lane_done_b_reg) begin
                        addr_reg  <= {bin_a_reg, bin_b_reg};
                        rw_reg    <= '0;
                        state_reg <= T_RMW;
                    end
                end
                T_RMW: begin
                    rw_reg <= rw_reg + 1'b1;
                    if (rw_reg == 2'd2) begin
                        state_reg <= T_OUT;
                        m_tvalid  <= 1'b1;
                    end
                end
                T_READ:  state_reg <= T_WAITR;
                T_WAITR: begin
                    binv_reg  <= ram_rdata;
                    state_reg <= T_OUT;
                    m_tvalid  <= 1'b1;
                end
                T_OUT: if (m_tready) begin
                    m_tvalid  <= 1'b0;
                    state_reg <= T_IDLE;
                end
                default: state_reg <= T_IDLE;
            endcase
            // A clear transaction holds its result while the sweep runs.
            if (state_reg == T_CLEAR && m_tvalid && m_tready) m_tvalid <= 1'b0;
        end
    end

    assign m_tdata = {7'd0, binv_reg, count_reg, small_b, small_a, big_b, big_a,
                      mean_b, mean_a, acc_reg};

    // Checks.
    a_no_take_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != T_IDLE) |-> !s_tready) else $error("input taken while busy");
    a_lanes_together: assert property (@(posedge aclk) disable iff (!aresetn)
        req_a.start |-> req_b.start) else $error("lanes started apart");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg != $past(count_reg)) |-> $past(req_a.start))
        else $error("count moved without insert");
    a_one_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready) |=> !m_tvalid) else $error("result repeated");
endmodule
